### design/ritp_pkg.sv
// Shared types, codes and the character classifier for the regex infix to
// postfix converter. Used by the controller, the datapath and the top level.
// No dependencies.
package ritp_pkg;

  // Fixed field widths
  localparam int CharW   = 8;
  localparam int KindW   = 3;
  localparam int AltW    = 4;
  localparam int FrameW  = AltW + 1;

  // Most pending alternations per nesting level
  localparam logic [AltW-1:0] MaxAlternatives = 4'd15;

  // Output token kinds
  localparam logic [KindW-1:0] TK_LIT  = 3'd0;
  localparam logic [KindW-1:0] TK_ANY  = 3'd1;
  localparam logic [KindW-1:0] TK_CAT  = 3'd2;
  localparam logic [KindW-1:0] TK_ALT  = 3'd3;
  localparam logic [KindW-1:0] TK_OPT  = 3'd4;
  localparam logic [KindW-1:0] TK_STAR = 3'd5;
  localparam logic [KindW-1:0] TK_PLUS = 3'd6;
  localparam logic [KindW-1:0] TK_END  = 3'd7;

  // Pattern metacharacters
  localparam logic [CharW-1:0] CH_OPEN  = 8'h28;  // (
  localparam logic [CharW-1:0] CH_CLOSE = 8'h29;  // )
  localparam logic [CharW-1:0] CH_BAR   = 8'h7C;  // |
  localparam logic [CharW-1:0] CH_OPT   = 8'h3F;  // ?
  localparam logic [CharW-1:0] CH_STAR  = 8'h2A;  // *
  localparam logic [CharW-1:0] CH_PLUS  = 8'h2B;  // +
  localparam logic [CharW-1:0] CH_ANY   = 8'h2E;  // .

  typedef enum logic [2:0] {
    CL_LIT,
    CL_ANY,
    CL_OPEN,
    CL_CLOSE,
    CL_BAR,
    CL_OPT,
    CL_STAR,
    CL_PLUS
  } cls_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PRECAT,
    OP_PUSH,
    OP_CLOSE_ALT,
    OP_POP,
    OP_BAR,
    OP_MAIN,
    OP_FL_CAT,
    OP_FL_ALT,
    OP_END
  } op_t;

  typedef struct packed {
    op_t  op;
    logic last;
  } cmd_t;

  typedef struct packed {
    cls_t cls;
    logic skip;
    logic eop;
    logic atom2;
    logic alt_nz;
    logic alt_one;
    logic level_nz;
    logic slot;
  } status_t;

  function automatic cls_t classify(input logic [CharW-1:0] ch);
    cls_t c;
    unique case (ch)
      CH_OPEN:  c = CL_OPEN;
      CH_CLOSE: c = CL_CLOSE;
      CH_BAR:   c = CL_BAR;
      CH_OPT:   c = CL_OPT;
      CH_STAR:  c = CL_STAR;
      CH_PLUS:  c = CL_PLUS;
      CH_ANY:   c = CL_ANY;
      default:  c = CL_LIT;
    endcase
    return c;
  endfunction

endpackage

### design/ritp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ritp_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/ritp_ctrl.sv
// Sequencer for the regex infix to postfix converter: steps each pattern byte
// through its token phases. Depends on ritp_pkg.
module ritp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  ritp_pkg::status_t st,
  output ritp_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRE,
    S_ACT,
    S_POP,
    S_FLUSH
  } state_t;

  state_t state, state_next;

  logic needs_fold;

  assign s_tready = (state == S_IDLE);

  // Characters that fold a pending concatenation before acting
  assign needs_fold = (st.cls != ritp_pkg::CL_OPT) && (st.cls != ritp_pkg::CL_STAR)
                   && (st.cls != ritp_pkg::CL_PLUS);

  // Pick the next datapath operation
  always_comb begin
    state_next = state;
    cmd.op     = ritp_pkg::OP_NONE;
    cmd.last   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.op     = ritp_pkg::OP_LOAD;
          state_next = S_PRE;
        end
      end
      S_PRE: begin
        if (st.skip) begin
          state_next = S_FLUSH;
        end else if (needs_fold && st.atom2) begin
          if (st.slot) begin
            cmd.op     = ritp_pkg::OP_PRECAT;
            cmd.last   = !st.eop && ((st.cls == ritp_pkg::CL_OPEN)
                      || (st.cls == ritp_pkg::CL_BAR)
                      || ((st.cls == ritp_pkg::CL_CLOSE) && !st.alt_nz));
            state_next = S_ACT;
          end
        end else begin
          state_next = S_ACT;
        end
      end
      S_ACT: begin
        unique case (st.cls)
          ritp_pkg::CL_OPEN: begin
            cmd.op     = ritp_pkg::OP_PUSH;
            state_next = S_FLUSH;
          end
          ritp_pkg::CL_CLOSE: begin
            if (st.alt_nz) begin
              if (st.slot) begin
                cmd.op   = ritp_pkg::OP_CLOSE_ALT;
                cmd.last = !st.eop && st.alt_one;
              end
            end else begin
              state_next = S_POP;
            end
          end
          ritp_pkg::CL_BAR: begin
            cmd.op     = ritp_pkg::OP_BAR;
            state_next = S_FLUSH;
          end
          default: begin
            if (st.slot) begin
              cmd.op     = ritp_pkg::OP_MAIN;
              cmd.last   = !st.eop;
              state_next = S_FLUSH;
            end
          end
        endcase
      end
      S_POP: begin
        cmd.op     = ritp_pkg::OP_POP;
        state_next = S_FLUSH;
      end
      S_FLUSH: begin
        if (!st.eop) begin
          state_next = S_IDLE;
        end else if (st.slot) begin
          priority if (st.level_nz) begin
            cmd.op     = ritp_pkg::OP_END;
            cmd.last   = 1'b1;
            state_next = S_IDLE;
          end else if (st.atom2) begin
            cmd.op = ritp_pkg::OP_FL_CAT;
          end else if (st.alt_nz) begin
            cmd.op = ritp_pkg::OP_FL_ALT;
          end else begin
            cmd.op     = ritp_pkg::OP_END;
            cmd.last   = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### design/ritp_dp.sv
// Datapath of the regex infix to postfix converter: pending counts, group
// stack, error flag and output register. Depends on ritp_pkg and ritp_ram.
module ritp_dp #(
  parameter int MAX_NESTING = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        s_tdata,
  input  logic              s_tlast,
  input  ritp_pkg::cmd_t    cmd,
  output ritp_pkg::status_t st,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata,
  output logic              m_tlast,
  output logic              m_tuser
);

  localparam int LW = $clog2(MAX_NESTING + 1);
  localparam int AW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;

  // Current item
  logic [ritp_pkg::CharW-1:0] ch;
  logic                       eop;
  ritp_pkg::cls_t             cls;
  logic                       skip;

  // Pending state
  logic [1:0]                 atom;
  logic [ritp_pkg::AltW-1:0]  alt;
  logic [LW-1:0]              level;
  logic                       error_seen;

  // Output register
  logic [ritp_pkg::KindW-1:0] out_kind;
  logic [ritp_pkg::CharW-1:0] out_lit;

  // Group stack
  logic                        stk_we;
  logic [ritp_pkg::FrameW-1:0] stk_rdata;
  logic [LW-1:0]               lvl_dec;

  // Load-time checks
  ritp_pkg::cls_t             cls_in;
  logic                       ovf_in;
  logic                       lvl_after_nz;
  logic                       err_item;

  // Emission
  logic                       emit;
  logic [ritp_pkg::KindW-1:0] emit_kind;
  logic [ritp_pkg::CharW-1:0] emit_lit;
  logic                       slot;

  assign slot    = !m_tvalid || m_tready;
  assign lvl_dec = level - LW'(1);
  assign stk_we  = (cmd.op == ritp_pkg::OP_PUSH);

  ritp_ram #(
    .WIDTH (ritp_pkg::FrameW),
    .DEPTH (MAX_NESTING)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (level[AW-1:0]),
    .wdata ({atom[0], alt}),
    .raddr (lvl_dec[AW-1:0]),
    .rdata (stk_rdata)
  );

  // Classify the incoming byte and find its errors
  always_comb begin
    cls_in = ritp_pkg::classify(s_tdata);
    ovf_in = ((cls_in == ritp_pkg::CL_OPEN) && (level >= LW'(MAX_NESTING)))
          || ((cls_in == ritp_pkg::CL_CLOSE) && (level == '0))
          || ((cls_in == ritp_pkg::CL_BAR) && (alt >= ritp_pkg::MaxAlternatives));
    unique case (cls_in)
      ritp_pkg::CL_OPEN:  lvl_after_nz = 1'b1;
      ritp_pkg::CL_CLOSE: lvl_after_nz = (level > LW'(1));
      default:            lvl_after_nz = (level != '0);
    endcase
    err_item = ovf_in || (s_tlast && lvl_after_nz);
  end

  // Select the token that this operation emits
  always_comb begin
    emit      = 1'b0;
    emit_kind = ritp_pkg::TK_END;
    emit_lit  = '0;
    unique case (cmd.op)
      ritp_pkg::OP_PRECAT, ritp_pkg::OP_FL_CAT: begin
        emit      = 1'b1;
        emit_kind = ritp_pkg::TK_CAT;
      end
      ritp_pkg::OP_CLOSE_ALT, ritp_pkg::OP_FL_ALT: begin
        emit      = 1'b1;
        emit_kind = ritp_pkg::TK_ALT;
      end
      ritp_pkg::OP_MAIN: begin
        emit = 1'b1;
        unique case (cls)
          ritp_pkg::CL_LIT: begin
            emit_kind = ritp_pkg::TK_LIT;
            emit_lit  = ch;
          end
          ritp_pkg::CL_ANY:  emit_kind = ritp_pkg::TK_ANY;
          ritp_pkg::CL_OPT:  emit_kind = ritp_pkg::TK_OPT;
          ritp_pkg::CL_STAR: emit_kind = ritp_pkg::TK_STAR;
          default:           emit_kind = ritp_pkg::TK_PLUS;
        endcase
      end
      ritp_pkg::OP_END: begin
        emit      = 1'b1;
        emit_kind = ritp_pkg::TK_END;
      end
      default: emit = 1'b0;
    endcase
  end

  // Latch the item's byte and class
  always_ff @(posedge clk) begin
    if (cmd.op == ritp_pkg::OP_LOAD) begin
      ch   <= s_tdata;
      eop  <= s_tlast;
      cls  <= cls_in;
      skip <= ovf_in;
    end
  end

  // Advance pending counts, nesting level and error flag
  always_ff @(posedge clk) begin
    if (rst) begin
      atom       <= '0;
      alt        <= '0;
      level      <= '0;
      error_seen <= 1'b0;
    end else begin
      unique case (cmd.op)
        ritp_pkg::OP_LOAD: begin
          error_seen <= error_seen | err_item;
        end
        ritp_pkg::OP_PRECAT, ritp_pkg::OP_FL_CAT: begin
          atom <= 2'd1;
        end
        ritp_pkg::OP_PUSH: begin
          level <= level + LW'(1);
          atom  <= '0;
          alt   <= '0;
        end
        ritp_pkg::OP_CLOSE_ALT, ritp_pkg::OP_FL_ALT: begin
          alt <= alt - ritp_pkg::AltW'(1);
        end
        ritp_pkg::OP_POP: begin
          level <= lvl_dec;
          atom  <= {1'b0, stk_rdata[ritp_pkg::AltW]} + {1'b0, (atom != '0)};
          alt   <= stk_rdata[ritp_pkg::AltW-1:0];
        end
        ritp_pkg::OP_BAR: begin
          atom <= '0;
          alt  <= alt + ritp_pkg::AltW'(1);
        end
        ritp_pkg::OP_MAIN: begin
          if ((cls == ritp_pkg::CL_LIT) || (cls == ritp_pkg::CL_ANY)) begin
            atom <= atom + 2'd1;
          end
        end
        ritp_pkg::OP_END: begin
          atom       <= '0;
          alt        <= '0;
          level      <= '0;
          error_seen <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Output beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output beat payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind <= emit_kind;
      out_lit  <= emit_lit;
      m_tlast  <= cmd.last;
      m_tuser  <= error_seen;
    end
  end

  assign m_tdata = {5'd0, out_lit, out_kind};

  // Status to the controller
  always_comb begin
    st.cls      = cls;
    st.skip     = skip;
    st.eop      = eop;
    st.atom2    = (atom == 2'd2);
    st.alt_nz   = (alt != '0);
    st.alt_one  = (alt == ritp_pkg::AltW'(1));
    st.level_nz = (level != '0);
    st.slot     = slot;
  end

`ifndef SYNTHESIS
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    level <= LW'(MAX_NESTING))
    else $error("nesting level beyond stack depth");

  a_atom_range: assert property (@(posedge clk) disable iff (rst)
    atom != 2'd3)
    else $error("pending atom count out of range");

  a_alt_range: assert property (@(posedge clk) disable iff (rst)
    alt <= ritp_pkg::MaxAlternatives)
    else $error("pending alternation count out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit && m_tvalid |-> m_tready)
    else $error("token emitted over an untaken beat");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.op == ritp_pkg::OP_END |=> level == '0 && alt == '0 && !error_seen)
    else $error("state not cleared after end token");
`endif

endmodule

### design/regex_infix_to_postfix.sv
// Top level of the regex infix to postfix converter: joins the sequencer and
// the datapath. Depends on ritp_pkg, ritp_ctrl and ritp_dp.
//
// Takes one pattern byte per input beat and emits postfix tokens, one per
// output beat, through a single output register; the beat with tlast closes
// the pattern, flushes the pending operators, emits the end token and clears
// all state. One byte at a time is in work: a load, a pre-concatenation
// step, an action step and a flush step (a byte dropped as an error skips
// the action step), plus an alternation token for each alternation that a
// ')' flushes, a pop step (stack read) for a ')' that restores its group,
// and for the last byte of a pattern one token per flushed concatenation
// and alternation. Output stalls hold the sequencer, since every token
// steps through the output register. MAX_NESTING sets the group stack depth.
module regex_infix_to_postfix #(
  parameter int MAX_NESTING = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] pattern_char
  input  logic        s_tlast,   // end_of_pattern
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [2:0] token_kind, [10:3] literal_value, rest zero
  output logic        m_tlast,   // last_of_run
  output logic        m_tuser    // [0] syntax_error
);

  ritp_pkg::cmd_t    cmd;
  ritp_pkg::status_t st;

  ritp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  ritp_dp #(
    .MAX_NESTING (MAX_NESTING)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .cmd      (cmd),
    .st       (st),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
